@@ rtl/assert_macros.svh @@
// Assertion helpers included by the generator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge of clk outside reset.
`define DPOG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that cons holds in the cycle after ante.
`define DPOG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dpog_pkg.sv @@
package dpog_pkg;

  localparam int CFG_W        = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_MAX      = 2047;
  localparam int OUT_POS_W    = 10;
  localparam int IDX_W        = 20;
  localparam int MAX_ROWS_DEF = 1024;
  localparam int MAX_COLS_DEF = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_ROWS  = 2'd0,
    REG_NUM_COLS  = 2'd1,
    REG_DIRECTION = 2'd2
  } cfg_reg_t;

  // Position width: the effective size never exceeds what the register can hold.
  function automatic int pos_width(input int max_size);
    int m;
    m = (max_size > CFG_MAX) ? CFG_MAX : max_size;
    return $clog2(m);
  endfunction

endpackage

@@ rtl/diagonal_pair_order_generator_core.sv @@
// Diagonal scan address generator for a rows-by-columns grid.
// Configuration: write num_rows (index 0), num_cols (index 1) and direction
// (index 2) through cfg_write/cfg_index/cfg_data while no beat is in flight.
// Sizes of zero act as one; sizes above MAX_ROWS/MAX_COLS saturate.
// Input channel: in_valid/in_ready with one restart bit per beat; restart
// set jumps to the bottom-left cell, clear advances along the walk.
// Output channel: out_valid/out_ready with row, col, seq_index and last,
// where last marks the top-right cell. The walk wraps after the last cell.
// An accepted input beat appears as its output beat in the next cycle.
// Throughput: one beat per cycle while out_ready is high; the cell position
// and index registers close a loop through the combinational step logic.
// The output register is also the walk state, so a new input beat is taken
// in the same cycle the pending output beat leaves.
// If out_ready is low, the output beat holds and in_ready drops.
// Reset empties the output and makes the next input beat emit the first cell.
module diagonal_pair_order_generator_core
  import dpog_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 restart,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_POS_W-1:0] row,
  output logic [OUT_POS_W-1:0] col,
  output logic [IDX_W-1:0]     seq_index,
  output logic                 last
);

`include "assert_macros.svh"

  localparam int ROW_W = pos_width(MAX_ROWS);
  localparam int COL_W = pos_width(MAX_COLS);

  logic [ROW_W-1:0] rows_m1;
  logic [COL_W-1:0] cols_m1;
  logic             direction;

  logic [ROW_W-1:0] cur_row, row_next;
  logic [COL_W-1:0] cur_col, col_next;
  logic [IDX_W-1:0] index_next;
  logic             last_next;
  logic             at_start;
  logic             in_fire;

  dpog_cfg #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .ROW_W    (ROW_W),
    .COL_W    (COL_W)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rows_m1   (rows_m1),
    .cols_m1   (cols_m1),
    .direction (direction)
  );

  dpog_step #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .ROW_W    (ROW_W),
    .COL_W    (COL_W)
  ) u_step (
    .restart    (restart),
    .at_start   (at_start),
    .direction  (direction),
    .rows_m1    (rows_m1),
    .cols_m1    (cols_m1),
    .cur_row    (cur_row),
    .cur_col    (cur_col),
    .cur_index  (seq_index),
    .row_next   (row_next),
    .col_next   (col_next),
    .index_next (index_next),
    .last_next  (last_next)
  );

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      at_start  <= 1'b1;
      cur_row   <= '0;
      cur_col   <= '0;
      seq_index <= '0;
      last      <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
      at_start  <= 1'b0;
      cur_row   <= row_next;
      cur_col   <= col_next;
      seq_index <= index_next;
      last      <= last_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign row = OUT_POS_W'(cur_row);
  assign col = OUT_POS_W'(cur_col);

  `DPOG_ASSERT_NEXT(a_fire_gives_beat, clk, rst, in_fire, out_valid,
                    "accepted input produced no output beat")
  `DPOG_ASSERT_NEXT(a_restart_first, clk, rst, in_fire && restart,
                    seq_index == '0 && cur_col == '0 && cur_row == rows_m1,
                    "restart did not emit the first cell")
  `DPOG_ASSERT(a_last_corner, clk, rst,
               out_valid && last |-> cur_row == '0 && cur_col == cols_m1,
               "last flag away from the top-right cell")

endmodule

@@ rtl/dpog_cfg.sv @@
module dpog_cfg
  import dpog_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int ROW_W    = pos_width(MAX_ROWS),
  parameter int COL_W    = pos_width(MAX_COLS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic [ROW_W-1:0]     rows_m1,
  output logic [COL_W-1:0]     cols_m1,
  output logic                 direction
);

  logic [ROW_W-1:0] rows_m1_next;
  logic [COL_W-1:0] cols_m1_next;

  // Store size minus one, with zero taken as one and oversize saturated.
  always_comb begin
    if (cfg_data == '0) begin
      rows_m1_next = '0;
      cols_m1_next = '0;
    end else begin
      if (32'(cfg_data) > 32'(MAX_ROWS)) begin
        rows_m1_next = ROW_W'(MAX_ROWS - 1);
      end else begin
        rows_m1_next = ROW_W'(cfg_data - 1'b1);
      end
      if (32'(cfg_data) > 32'(MAX_COLS)) begin
        cols_m1_next = COL_W'(MAX_COLS - 1);
      end else begin
        cols_m1_next = COL_W'(cfg_data - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m1   <= '0;
      cols_m1   <= '0;
      direction <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NUM_ROWS:  rows_m1   <= rows_m1_next;
        REG_NUM_COLS:  cols_m1   <= cols_m1_next;
        REG_DIRECTION: direction <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/dpog_step.sv @@
module dpog_step
  import dpog_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int ROW_W    = pos_width(MAX_ROWS),
  parameter int COL_W    = pos_width(MAX_COLS)
) (
  input  logic             restart,
  input  logic             at_start,
  input  logic             direction,
  input  logic [ROW_W-1:0] rows_m1,
  input  logic [COL_W-1:0] cols_m1,
  input  logic [ROW_W-1:0] cur_row,
  input  logic [COL_W-1:0] cur_col,
  input  logic [IDX_W-1:0] cur_index,
  output logic [ROW_W-1:0] row_next,
  output logic [COL_W-1:0] col_next,
  output logic [IDX_W-1:0] index_next,
  output logic             last_next
);

  localparam int SW = ((ROW_W > COL_W) ? ROW_W : COL_W) + 2;

  logic                 to_first;
  logic signed [SW-1:0] r_s, c_s, rm_s, cm_s, nd, top, r_dn;

  assign r_s  = SW'(cur_row);
  assign c_s  = SW'(cur_col);
  assign rm_s = SW'(rows_m1);
  assign cm_s = SW'(cols_m1);
  assign nd   = r_s - c_s - SW'(1);
  assign top  = nd + cm_s;
  assign r_dn = (top < rm_s) ? top : rm_s;

  // Restart also covers the final cell and a position left outside the grid.
  assign to_first = restart || at_start || (cur_row > rows_m1) || (cur_col > cols_m1) ||
                    ((cur_row == '0) && (cur_col == cols_m1));

  always_comb begin
    if (to_first) begin
      row_next = rows_m1;
      col_next = '0;
    end else if (!direction) begin
      if ((cur_row == rows_m1) || (cur_col == cols_m1)) begin
        // enter the next diagonal at its smallest row
        if (nd >= 0) begin
          row_next = ROW_W'(nd);
          col_next = '0;
        end else begin
          row_next = '0;
          col_next = COL_W'(-nd);
        end
      end else begin
        row_next = cur_row + 1'b1;
        col_next = cur_col + 1'b1;
      end
    end else begin
      if ((cur_row == '0) || (cur_col == '0)) begin
        // enter the next diagonal at its largest row
        row_next = ROW_W'(r_dn);
        col_next = COL_W'(r_dn - nd);
      end else begin
        row_next = cur_row - 1'b1;
        col_next = cur_col - 1'b1;
      end
    end
  end

  assign index_next = to_first ? '0 : cur_index + 1'b1;
  assign last_next  = (row_next == '0) && (col_next == cols_m1);

endmodule

@@ tb/tb_top.sv @@
`default_nettype none

module tb_top
  import dpog_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BEATS = 650;
  localparam int HOLD_CYCLES  = 64;
  localparam int STALL_LIMIT  = 4000;
  localparam int PRINT_CAP    = 40;

  typedef struct packed {
    logic [OUT_POS_W-1:0] row;
    logic [OUT_POS_W-1:0] col;
    logic [IDX_W-1:0]     seq;
    logic                 is_last;
  } cell_t;

  // Tracks the walk position and holds the cells still owed by the block.
  class diag_walk_board;
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    logic             dir_reg;
    int               cur_row;
    int               cur_col;
    logic [IDX_W-1:0] cur_seq;
    bit               at_start;
    cell_t            owed_cells[$];
    int               errors;
    int               checked;

    function new();
      rows_reg = CFG_W'(1);
      cols_reg = CFG_W'(1);
      dir_reg  = 1'b0;
      cur_row  = 0;
      cur_col  = 0;
      cur_seq  = '0;
      at_start = 1'b1;
      errors   = 0;
      checked  = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_NUM_ROWS:  rows_reg = data;
        REG_NUM_COLS:  cols_reg = data;
        REG_DIRECTION: dir_reg  = data[0];
        default: ;
      endcase
    endfunction

    function int grid_size(logic [CFG_W-1:0] v, int max_v);
      if (v == 0) return 1;
      if (int'(v) > max_v) return max_v;
      return int'(v);
    endfunction

    function int pending();
      return owed_cells.size();
    endfunction

    function void note_beat(logic rs);
      int    rows;
      int    cols;
      int    r;
      int    c;
      int    nd;
      int    top;
      cell_t item;
      rows = grid_size(rows_reg, MAX_ROWS_DEF);
      cols = grid_size(cols_reg, MAX_COLS_DEF);
      r = cur_row;
      c = cur_col;
      if (rs || at_start || r >= rows || c >= cols || (r == 0 && c == cols - 1)) begin
        r = rows - 1;
        c = 0;
        cur_seq = '0;
      end else begin
        nd = r - c - 1;
        if (!dir_reg) begin
          // descend the diagonal; on leaving the grid enter the next one at its top
          if (r == rows - 1 || c == cols - 1) begin
            if (nd >= 0) begin
              r = nd;
              c = 0;
            end else begin
              r = 0;
              c = -nd;
            end
          end else begin
            r++;
            c++;
          end
        end else begin
          if (r == 0 || c == 0) begin
            top = nd + cols - 1;
            r = (top < rows - 1) ? top : rows - 1;
            c = r - nd;
          end else begin
            r--;
            c--;
          end
        end
        cur_seq = cur_seq + 1'b1;
      end
      cur_row  = r;
      cur_col  = c;
      at_start = 1'b0;
      item.row     = r[OUT_POS_W-1:0];
      item.col     = c[OUT_POS_W-1:0];
      item.seq     = cur_seq;
      item.is_last = (r == 0 && c == cols - 1);
      owed_cells.push_back(item);
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("[%0t] %s", $time, msg);
      errors++;
    endtask

    task check_beat(cell_t got);
      cell_t want;
      string bad;
      if (owed_cells.size() == 0) begin
        report($sformatf("unexpected beat: row %0d col %0d seq %0d last %0b",
                         got.row, got.col, got.seq, got.is_last));
        return;
      end
      want = owed_cells.pop_front();
      bad  = "";
      if (got.row !== want.row)
        bad = {bad, $sformatf(" row exp %0d got %0d", want.row, got.row)};
      if (got.col !== want.col)
        bad = {bad, $sformatf(" col exp %0d got %0d", want.col, got.col)};
      if (got.seq !== want.seq)
        bad = {bad, $sformatf(" seq exp %0d got %0d", want.seq, got.seq)};
      if (got.is_last !== want.is_last)
        bad = {bad, $sformatf(" last exp %0b got %0b", want.is_last, got.is_last)};
      if (bad != "") report($sformatf("beat %0d mismatch:%s", checked, bad));
      checked++;
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 restart = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_POS_W-1:0] row;
  logic [OUT_POS_W-1:0] col;
  logic [IDX_W-1:0]     seq_index;
  logic                 last;

  diag_walk_board board = new();
  bit hold_req   = 1'b0;
  int beats_sent = 0;
  int burst_left = 0;
  int stall_cycles = 0;

  diagonal_pair_order_generator_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .row       (row),
    .col       (col),
    .seq_index (seq_index),
    .last      (last)
  );

  always #5ns clk = ~clk;

  // Check the outgoing beat before noting the incoming one at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (out_valid && out_ready)
        board.check_beat('{row: row, col: col, seq: seq_index, is_last: last});
      if (in_valid && in_ready) board.note_beat(restart);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Receiver: ready follows a randomly re-picked pattern; long hold on request.
  initial begin
    int rx_cycle;
    int rx_mode;
    rx_cycle = 0;
    rx_mode  = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rx_cycle++;
      if (rx_cycle % 48 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= rx_cycle[2];
      endcase
    end
  end

  task send_beat(input logic rs);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 :
            $urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 4);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    restart  <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    beats_sent++;
  endtask

  // Drop valid and wait until every owed cell has left the block.
  task drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
  endtask

  // sel bits: 0 rows, 1 cols, 2 direction
  task write_config(input int rows_v, input int cols_v, input bit dir_v,
                    input bit [2:0] sel);
    cfg_reg_t          idx;
    logic [CFG_W-1:0] data;
    drain();
    for (int i = 0; i < 3; i++) begin
      if (sel[i]) begin
        idx  = cfg_reg_t'(i);
        data = (idx == REG_NUM_ROWS) ? rows_v[CFG_W-1:0] :
               (idx == REG_NUM_COLS) ? cols_v[CFG_W-1:0] : CFG_W'(dir_v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.write_reg(idx, data);
        cfg_write <= 1'b0;
      end
    end
  endtask

  function int pick_large();
    case ($urandom_range(0, 3))
      0: return 1024;
      1: return 2047;
      2: return 1023;
      default: return $urandom_range(1025, 2046);
    endcase
  endfunction

  initial begin
    int phase;
    int n;
    int kind;
    int rows_v;
    int cols_v;
    int stop_at;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // default 1x1 grid: every beat lands on the only cell
    send_beat(1'b0);
    send_beat(1'b0);
    send_beat(1'b0);
    send_beat(1'b1);
    // zero sizes act as one
    write_config(0, 0, 1'b1, 3'b111);
    send_beat(1'b0);
    send_beat(1'b0);
    // oversize rows saturate
    write_config(2047, 2, 1'b0, 3'b111);
    send_beat(1'b0);
    send_beat(1'b0);
    send_beat(1'b0);
    send_beat(1'b1);
    send_beat(1'b0);
    // full 3x3 walk, wrap past the last cell, then shrink under the position
    write_config(3, 3, 1'b0, 3'b111);
    repeat (12) send_beat(1'b0);
    write_config(0, 1, 1'b0, 3'b010);
    send_beat(1'b0);
    send_beat(1'b0);

    stop_at = beats_sent + RANDOM_BEATS;
    phase = 0;
    while (beats_sent < stop_at) begin
      kind   = $urandom_range(0, 9);
      rows_v = $urandom_range(1, 12);
      cols_v = $urandom_range(1, 12);
      case (kind)
        // set a random direction mid-walk
        0: write_config(0, 0, 1'($urandom_range(0, 1)), 3'b100);
        // resize only; the stored cell may fall outside the grid
        1: write_config(rows_v, cols_v, 1'b0, 3'b011);
        2: begin
          if ($urandom_range(0, 1)) rows_v = pick_large();
          else cols_v = pick_large();
          if (rows_v > 12) cols_v = $urandom_range(1, 4);
          else rows_v = $urandom_range(1, 4);
          write_config(rows_v, cols_v, 1'($urandom_range(0, 1)), 3'b111);
        end
        3: write_config($urandom_range(0, 3), $urandom_range(0, 3),
                        1'($urandom_range(0, 1)), 3'b111);
        default: write_config(rows_v, cols_v, 1'($urandom_range(0, 1)), 3'b111);
      endcase
      // stall the receiver long enough to back the input up
      if (phase == 2 || phase == 9) hold_req = 1'b1;
      n = $urandom_range(15, 60);
      repeat (n) send_beat($urandom_range(0, 29) == 0);
      phase++;
    end

    drain();
    repeat (5) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
